// File: src/danms_pkg.sv
// ----------------------------------------------------------------------------
// danms_pkg: shared types and helpers for the detection decode / NMS block
// Holds the queue word, candidate record, configuration bundle and state enum.
// ----------------------------------------------------------------------------
package danms_pkg;

  localparam int CLASS_COUNT_DEF     = 80;
  localparam int CANDIDATE_SLOTS_DEF = 64;
  localparam int QUEUE_DEPTH         = 4;
  localparam int QUEUE_AW            = 2;

  // configuration register indexes
  localparam logic [2:0] CFG_ZP_OFFSET         = 3'd0;
  localparam logic [2:0] CFG_SCALE_Q24         = 3'd1;
  localparam logic [2:0] CFG_SCORE_THRESHOLD   = 3'd2;
  localparam logic [2:0] CFG_OVERLAP_THRESHOLD = 3'd3;
  localparam logic [2:0] CFG_IMAGE_WIDTH       = 3'd4;
  localparam logic [2:0] CFG_IMAGE_HEIGHT      = 3'd5;

  typedef struct packed {
    logic signed [7:0]  zp_offset;
    logic [23:0]        scale_q24;
    logic signed [7:0]  score_threshold;
    logic [8:0]         overlap_threshold;
    logic [11:0]        image_width;
    logic [11:0]        image_height;
  } cfg_t;

  // one finished box (or a bare end-of-frame mark) from front to back
  typedef struct packed {
    logic              has_box;
    logic              eof;
    logic signed [7:0] cx;
    logic signed [7:0] cy;
    logic signed [7:0] w;
    logic signed [7:0] h;
    logic signed [7:0] best;
    logic signed [7:0] cls;
  } job_t;

  typedef struct packed {
    logic signed [15:0] l;
    logic signed [15:0] t;
    logic signed [15:0] r;
    logic signed [15:0] b;
    logic signed [24:0] conf;
    logic signed [7:0]  cls;
    logic signed [7:0]  raw;
    logic signed [33:0] area;
  } cand_t;

  typedef struct packed {
    logic [6:0] count;
    logic       frame_busy;
  } back_status_t;

  typedef enum logic [4:0] {
    S_IDLE, S_CHECK, S_DEC, S_INS, S_INSC, S_FRAME,
    S_NI, S_NA, S_NJ, S_NB, S_N1, S_N2, S_N3, S_N4,
    S_LAST, S_EI, S_EO, S_CLEAR
  } back_state_t;

  function automatic logic signed [15:0] sat16(input logic signed [47:0] v);
    if (v > 48'sd32767) begin
      return 16'sh7fff;
    end else if (v < -48'sd32768) begin
      return 16'sh8000;
    end
    return v[15:0];
  endfunction

  // round(sd * (2*dc +/- dd) / 2^21), half up, saturated
  function automatic logic signed [15:0] corner(input logic signed [7:0] c,
                                                input logic signed [7:0] d,
                                                input logic signed [7:0] zp,
                                                input logic neg,
                                                input logic [35:0] sd);
    logic signed [8:0]  dc;
    logic signed [8:0]  dd;
    logic signed [10:0] term;
    logic signed [47:0] prod;
    dc   = 9'(c) - 9'(zp);
    dd   = 9'(d) - 9'(zp);
    term = neg ? ((11'(dc) <<< 1) - 11'(dd)) : ((11'(dc) <<< 1) + 11'(dd));
    prod = 48'(term) * 48'($signed({1'b0, sd}));
    return sat16((prod + 48'sd1048576) >>> 21);
  endfunction

endpackage

// File: src/danms_if.sv
// ----------------------------------------------------------------------------
// danms channel interfaces
// Element input, detection output and register write channels.
// ----------------------------------------------------------------------------
interface danms_in_if;
  logic              valid;
  logic              ready;
  logic signed [7:0] element;
  logic              end_of_frame;
  modport source (output valid, element, end_of_frame, input ready);
  modport sink   (input valid, element, end_of_frame, output ready);
endinterface

interface danms_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] left;
  logic signed [15:0] top;
  logic signed [15:0] right;
  logic signed [15:0] bottom;
  logic signed [24:0] confidence;
  logic signed [7:0]  class_index;
  logic               box_valid;
  logic               last;
  modport source (output valid, left, top, right, bottom, confidence, class_index,
                  box_valid, last, input ready);
  modport sink   (input valid, left, top, right, bottom, confidence, class_index,
                  box_valid, last, output ready);
endinterface

interface danms_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [23:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: src/danms_front.sv
// ----------------------------------------------------------------------------
// danms_front: element stream parser
// Collects box coordinates and the first maximum class score per box.
// ----------------------------------------------------------------------------
module danms_front #(
  parameter int CLASS_COUNT = danms_pkg::CLASS_COUNT_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  danms_in_if.sink              din,
  output danms_pkg::job_t       push_data,
  output logic                  push_valid,
  input  logic                  push_ready
);
  localparam int PW = $clog2(CLASS_COUNT + 4);

  logic [PW-1:0]     pos;
  logic signed [7:0] coord [4];
  logic signed [7:0] best;
  logic signed [7:0] cls;

  logic              accept;
  logic              is_coord;
  logic              better;
  logic              done;
  logic signed [7:0] best_next;
  logic signed [7:0] cls_next;

  assign din.ready = push_ready;
  assign accept    = din.valid && din.ready;
  assign is_coord  = pos < PW'(4);
  assign better    = !is_coord && (din.element > best);
  assign done      = pos >= PW'(CLASS_COUNT + 3);
  assign best_next = better ? din.element : best;
  assign cls_next  = better ? 8'(pos - PW'(4)) : cls;

  always_comb begin
    push_valid        = accept && (done || din.end_of_frame);
    push_data.has_box = done;
    push_data.eof     = din.end_of_frame;
    push_data.cx      = coord[0];
    push_data.cy      = coord[1];
    push_data.w       = coord[2];
    push_data.h       = coord[3];
    push_data.best    = best_next;
    push_data.cls     = cls_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos  <= '0;
      best <= -8'sd128;
      cls  <= -8'sd1;
    end else if (accept) begin
      if (is_coord) begin
        coord[pos[1:0]] <= din.element;
      end
      if (done || din.end_of_frame) begin
        // drop any partial box at end of frame
        pos  <= '0;
        best <= -8'sd128;
        cls  <= -8'sd1;
      end else begin
        pos  <= pos + PW'(1);
        best <= best_next;
        cls  <= cls_next;
      end
    end
  end

endmodule

// File: src/danms_queue.sv
// ----------------------------------------------------------------------------
// danms_queue: short FIFO between parser and frame engine
// Lets the parser keep streaming while the back end decodes and inserts.
// ----------------------------------------------------------------------------
module danms_queue (
  input  logic            clk,
  input  logic            rst,
  input  danms_pkg::job_t push_data,
  input  logic            push_valid,
  output logic            push_ready,
  output danms_pkg::job_t pop_data,
  output logic            pop_valid,
  input  logic            pop_ready
);
  localparam int AW = danms_pkg::QUEUE_AW;

  danms_pkg::job_t mem [danms_pkg::QUEUE_DEPTH];
  logic [AW-1:0]   wr_ptr;
  logic [AW-1:0]   rd_ptr;
  logic [AW:0]     fill;
  logic            do_push;
  logic            do_pop;

  assign push_ready = fill != (AW+1)'(danms_pkg::QUEUE_DEPTH);
  assign pop_valid  = fill != '0;
  assign pop_data   = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + AW'(1);
      end
      if (do_push && !do_pop) begin
        fill <= fill + (AW+1)'(1);
      end else if (do_pop && !do_push) begin
        fill <= fill - (AW+1)'(1);
      end
    end
  end

endmodule

// File: src/danms_back.sv
// ----------------------------------------------------------------------------
// danms_back: frame engine
// Decodes kept boxes into a score-ordered store, runs per-class NMS, emits.
// ----------------------------------------------------------------------------
module danms_back #(
  parameter int CANDIDATE_SLOTS = danms_pkg::CANDIDATE_SLOTS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  danms_pkg::cfg_t         cfg,
  input  danms_pkg::job_t         pop_data,
  input  logic                    pop_valid,
  output logic                    pop_ready,
  danms_out_if.source             dout,
  output danms_pkg::back_status_t status
);
  localparam int IW = (CANDIDATE_SLOTS > 1) ? $clog2(CANDIDATE_SLOTS) : 1;
  localparam int CW = $clog2(CANDIDATE_SLOTS + 1);

  danms_pkg::back_state_t state;
  danms_pkg::back_state_t state_next;

  danms_pkg::cand_t mem [CANDIDATE_SLOTS];
  danms_pkg::cand_t rdata;
  danms_pkg::cand_t wdata;
  logic [IW-1:0]    waddr;
  logic [IW-1:0]    raddr;
  logic             we;
  logic             re;

  danms_pkg::job_t  job;
  danms_pkg::cand_t newc;
  danms_pkg::cand_t a;
  danms_pkg::cand_t b;
  logic [2:0]       step;
  logic [35:0]      sd;
  logic [CW-1:0]    pos;
  logic [CW-1:0]    count;
  logic [CW-1:0]    i;
  logic [CW-1:0]    j;
  logic [CW-1:0]    k;
  logic [CW-1:0]    lastk;
  logic [CANDIDATE_SLOTS-1:0] keep;
  logic [15:0]      wdt;
  logic [15:0]      hgt;
  logic [31:0]      inter;
  logic signed [35:0] uni;
  logic [39:0]      lhs;
  logic [44:0]      rhs;

  logic             out_free;
  logic             out_load;
  logic             take_box;
  logic             shift;
  logic             i_end;
  logic             j_end;
  logic             keep_i;
  logic             keep_j;
  logic signed [15:0] ix1, iy1, ix2, iy2;
  logic signed [16:0] ow, oh;

  assign out_free = !dout.valid || dout.ready;
  assign take_box = job.has_box && (job.best >= cfg.score_threshold)
                    && (count < CW'(CANDIDATE_SLOTS));
  assign shift    = rdata.raw < newc.raw;
  assign i_end    = i == count;
  assign j_end    = j == count;
  assign keep_i   = !i_end && keep[i[IW-1:0]];
  assign keep_j   = !j_end && keep[j[IW-1:0]];
  assign status.count      = 7'(count);
  assign status.frame_busy = state != danms_pkg::S_IDLE;

  // overlap box of a and the word just read
  assign ix1 = (a.l > rdata.l) ? a.l : rdata.l;
  assign iy1 = (a.t > rdata.t) ? a.t : rdata.t;
  assign ix2 = (a.r < rdata.r) ? a.r : rdata.r;
  assign iy2 = (a.b < rdata.b) ? a.b : rdata.b;
  assign ow  = 17'(ix2) - 17'(ix1);
  assign oh  = 17'(iy2) - 17'(iy1);

  always_comb begin
    state_next = state;
    unique case (state)
      danms_pkg::S_IDLE:  if (pop_valid) state_next = danms_pkg::S_CHECK;
      danms_pkg::S_CHECK: begin
        if (take_box) state_next = danms_pkg::S_DEC;
        else if (job.eof) state_next = danms_pkg::S_FRAME;
        else state_next = danms_pkg::S_IDLE;
      end
      danms_pkg::S_DEC:   if (step == 3'd7) state_next = danms_pkg::S_INS;
      danms_pkg::S_INS: begin
        if (pos != '0) state_next = danms_pkg::S_INSC;
        else state_next = job.eof ? danms_pkg::S_FRAME : danms_pkg::S_IDLE;
      end
      danms_pkg::S_INSC: begin
        if (shift) state_next = danms_pkg::S_INS;
        else state_next = job.eof ? danms_pkg::S_FRAME : danms_pkg::S_IDLE;
      end
      danms_pkg::S_FRAME: begin
        if (count != '0) state_next = danms_pkg::S_NI;
        else if (out_free) state_next = danms_pkg::S_CLEAR;
      end
      danms_pkg::S_NI: begin
        if (i_end) state_next = danms_pkg::S_LAST;
        else if (keep_i) state_next = danms_pkg::S_NA;
      end
      danms_pkg::S_NA:    state_next = danms_pkg::S_NJ;
      danms_pkg::S_NJ: begin
        if (j_end) state_next = danms_pkg::S_NI;
        else if (keep_j) state_next = danms_pkg::S_NB;
      end
      danms_pkg::S_NB:
        state_next = (a.cls == rdata.cls) ? danms_pkg::S_N1 : danms_pkg::S_NJ;
      danms_pkg::S_N1:    state_next = danms_pkg::S_N2;
      danms_pkg::S_N2:    state_next = danms_pkg::S_N3;
      danms_pkg::S_N3:    state_next = danms_pkg::S_N4;
      danms_pkg::S_N4:    state_next = danms_pkg::S_NJ;
      danms_pkg::S_LAST:  if (keep[k[IW-1:0]]) state_next = danms_pkg::S_EI;
      danms_pkg::S_EI:    if (keep_i) state_next = danms_pkg::S_EO;
      danms_pkg::S_EO: begin
        if (out_free) state_next = (i == lastk) ? danms_pkg::S_CLEAR : danms_pkg::S_EI;
      end
      danms_pkg::S_CLEAR: state_next = danms_pkg::S_IDLE;
      default:            state_next = danms_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    pop_ready = 1'b0;
    we        = 1'b0;
    waddr     = pos[IW-1:0];
    wdata     = newc;
    re        = 1'b0;
    raddr     = i[IW-1:0];
    out_load  = 1'b0;
    unique case (state)
      danms_pkg::S_IDLE: pop_ready = 1'b1;
      danms_pkg::S_INS: begin
        if (pos == '0) begin
          we = 1'b1;
        end else begin
          re    = 1'b1;
          raddr = IW'(pos - CW'(1));
        end
      end
      danms_pkg::S_INSC: begin
        we = 1'b1;
        if (shift) wdata = rdata;
      end
      danms_pkg::S_FRAME: out_load = (count == '0) && out_free;
      danms_pkg::S_NI:    re = keep_i;
      danms_pkg::S_NJ: begin
        re    = keep_j;
        raddr = j[IW-1:0];
      end
      danms_pkg::S_EI:    re = keep_i;
      danms_pkg::S_EO:    out_load = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= danms_pkg::S_IDLE;
      count      <= '0;
      keep       <= '1;
      dout.valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) dout.valid <= 1'b1;
      else if (dout.ready) dout.valid <= 1'b0;

      case (state)
        danms_pkg::S_IDLE:  if (pop_valid) job <= pop_data;
        danms_pkg::S_CHECK: step <= '0;
        danms_pkg::S_DEC: begin
          step <= step + 3'd1;
          case (step)
            3'd0: sd <= 36'(cfg.scale_q24) * 36'(cfg.image_width);
            3'd1: newc.l <= danms_pkg::corner(job.cx, job.w, cfg.zp_offset, 1'b1, sd);
            3'd2: newc.r <= danms_pkg::corner(job.cx, job.w, cfg.zp_offset, 1'b0, sd);
            3'd3: sd <= 36'(cfg.scale_q24) * 36'(cfg.image_height);
            3'd4: newc.t <= danms_pkg::corner(job.cy, job.h, cfg.zp_offset, 1'b1, sd);
            3'd5: newc.b <= danms_pkg::corner(job.cy, job.h, cfg.zp_offset, 1'b0, sd);
            3'd6: begin
              newc.conf <= 25'((34'(9'(job.best) - 9'(cfg.zp_offset))
                                * 34'($signed({1'b0, cfg.scale_q24})) + 34'sd128) >>> 8);
              newc.cls  <= job.cls;
              newc.raw  <= job.best;
            end
            default: begin
              newc.area <= 34'(17'(newc.r) - 17'(newc.l)) * 34'(17'(newc.b) - 17'(newc.t));
              pos       <= count;
            end
          endcase
        end
        danms_pkg::S_INS:  if (pos == '0) count <= count + CW'(1);
        danms_pkg::S_INSC: begin
          if (shift) pos <= pos - CW'(1);
          else count <= count + CW'(1);
        end
        danms_pkg::S_FRAME: i <= '0;
        danms_pkg::S_NI: begin
          if (i_end) k <= count - CW'(1);
          else if (keep_i) j <= i + CW'(1);
          else i <= i + CW'(1);
        end
        danms_pkg::S_NA: a <= rdata;
        danms_pkg::S_NJ: begin
          if (j_end) i <= i + CW'(1);
          else if (!keep_j) j <= j + CW'(1);
        end
        danms_pkg::S_NB: begin
          b   <= rdata;
          wdt <= ow[16] ? 16'd0 : ow[15:0];
          hgt <= oh[16] ? 16'd0 : oh[15:0];
          if (a.cls != rdata.cls) j <= j + CW'(1);
        end
        danms_pkg::S_N1: inter <= 32'(wdt) * 32'(hgt);
        danms_pkg::S_N2: begin
          uni <= 36'(a.area) + 36'(b.area) - 36'($signed({1'b0, inter}));
          lhs <= {inter, 8'd0};
        end
        danms_pkg::S_N3: rhs <= 45'(cfg.overlap_threshold) * 45'(uni[34:0]);
        danms_pkg::S_N4: begin
          if ((uni > 36'sd0) && (45'(lhs) > rhs)) keep[j[IW-1:0]] <= 1'b0;
          j <= j + CW'(1);
        end
        danms_pkg::S_LAST: begin
          if (keep[k[IW-1:0]]) begin
            lastk <= k;
            i     <= '0;
          end else begin
            k <= k - CW'(1);
          end
        end
        danms_pkg::S_EI: if (!keep_i) i <= i + CW'(1);
        danms_pkg::S_EO: if (out_free && (i != lastk)) i <= i + CW'(1);
        danms_pkg::S_CLEAR: begin
          count <= '0;
          keep  <= '1;
        end
        default: ;
      endcase
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (out_load) begin
      if (state == danms_pkg::S_EO) begin
        dout.left        <= rdata.l;
        dout.top         <= rdata.t;
        dout.right       <= rdata.r;
        dout.bottom      <= rdata.b;
        dout.confidence  <= rdata.conf;
        dout.class_index <= rdata.cls;
        dout.box_valid   <= 1'b1;
        dout.last        <= i == lastk;
      end else begin
        dout.left        <= '0;
        dout.top         <= '0;
        dout.right       <= '0;
        dout.bottom      <= '0;
        dout.confidence  <= '0;
        dout.class_index <= '0;
        dout.box_valid   <= 1'b0;
        dout.last        <= 1'b1;
      end
    end
  end

endmodule

// File: src/detection_argmax_decode_nms.sv
// ----------------------------------------------------------------------------
// detection_argmax_decode_nms: detector post-processing top level
// Argmax, score threshold, box decode and per-class greedy NMS on int8 data.
// ----------------------------------------------------------------------------
// Usage:
//   din  : one int8 tensor word per cycle while ready, box-major (cx, cy,
//          w, h, CLASS_COUNT scores); end_of_frame marks a frame's last word.
//   dout : one word per surviving box in descending score order, last set on
//          the final one; an empty frame gives one word with box_valid 0.
//   cfg  : register writes (index, data), always ready; write only when idle.
// Flow: the parser takes one word per cycle while the queue has room; the
//   frame engine pops a job only when idle, after decoding and inserting the
//   last kept box; the 4-deep queue absorbs that, so din rarely stalls.
// End of frame: NMS skips cleared entries and other-class pairs and tests
//   each same-class pair's overlap; emission skips dropped entries and waits
//   on dout per survivor; din stalls once the queue fills.
// Reset: registers return to defaults, store count clears, no clearing pass.
// A stalled receiver holds dout and the engine waits; the parser keeps going
//   until the queue fills.
module detection_argmax_decode_nms #(
  parameter int CLASS_COUNT     = danms_pkg::CLASS_COUNT_DEF,
  parameter int CANDIDATE_SLOTS = danms_pkg::CANDIDATE_SLOTS_DEF
) (
  input logic         clk,
  input logic         rst,
  danms_in_if.sink    din,
  danms_out_if.source dout,
  danms_cfg_if.sink   cfg
);
  danms_pkg::cfg_t         cfg_regs;
  danms_pkg::job_t         push_data;
  danms_pkg::job_t         pop_data;
  danms_pkg::back_status_t status;
  logic push_valid, push_ready, pop_valid, pop_ready;

  assign cfg.ready = 1'b1;

  // register file; unknown indexes drop
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.zp_offset         <= 8'sd0;
      cfg_regs.scale_q24         <= 24'd65536;
      cfg_regs.score_threshold   <= 8'sd0;
      cfg_regs.overlap_threshold <= 9'd179;
      cfg_regs.image_width       <= 12'd640;
      cfg_regs.image_height      <= 12'd480;
    end else if (cfg.valid) begin
      case (cfg.index)
        danms_pkg::CFG_ZP_OFFSET:         cfg_regs.zp_offset         <= cfg.data[7:0];
        danms_pkg::CFG_SCALE_Q24:         cfg_regs.scale_q24         <= cfg.data;
        danms_pkg::CFG_SCORE_THRESHOLD:   cfg_regs.score_threshold   <= cfg.data[7:0];
        danms_pkg::CFG_OVERLAP_THRESHOLD: cfg_regs.overlap_threshold <= cfg.data[8:0];
        danms_pkg::CFG_IMAGE_WIDTH:       cfg_regs.image_width       <= cfg.data[11:0];
        danms_pkg::CFG_IMAGE_HEIGHT:      cfg_regs.image_height      <= cfg.data[11:0];
        default: ;
      endcase
    end
  end

  danms_front #(.CLASS_COUNT(CLASS_COUNT)) u_front (
    .clk(clk), .rst(rst), .din(din),
    .push_data(push_data), .push_valid(push_valid), .push_ready(push_ready)
  );

  danms_queue u_queue (
    .clk(clk), .rst(rst),
    .push_data(push_data), .push_valid(push_valid), .push_ready(push_ready),
    .pop_data(pop_data), .pop_valid(pop_valid), .pop_ready(pop_ready)
  );

  danms_back #(.CANDIDATE_SLOTS(CANDIDATE_SLOTS)) u_back (
    .clk(clk), .rst(rst), .cfg(cfg_regs),
    .pop_data(pop_data), .pop_valid(pop_valid), .pop_ready(pop_ready),
    .dout(dout), .status(status)
  );

`ifndef SYNTHESIS
  a_marker_last: assert property (@(posedge clk) disable iff (rst)
    dout.valid && !dout.box_valid |-> dout.last)
    else $error("empty-frame word without last");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    status.count <= 7'(CANDIDATE_SLOTS))
    else $error("store count beyond slots");
  a_reset_out: assert property (@(posedge clk)
    rst |=> !dout.valid)
    else $error("output valid right after reset");
  a_idle_on_reset: assert property (@(posedge clk)
    rst |=> !status.frame_busy && (status.count == 7'd0))
    else $error("frame engine busy after reset");
`endif

endmodule
